FILE: sv/asmd_pkg.sv
// asmd_pkg: widths, operation and status codes, and the pipeline stage type
// for the add/sub/mul/div unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package asmd_pkg;

    localparam int OPERAND_BITS  = 31;
    localparam int FRACTION_BITS = 4;
    localparam int WHOLE_BITS    = 2 * OPERAND_BITS;
    localparam int QUOT_BITS     = OPERAND_BITS + FRACTION_BITS;
    localparam int REM_BITS      = OPERAND_BITS + 1;
    localparam int STATUS_BITS   = 2;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_NEG  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef struct packed {
        logic                    valid;
        t_func                   func;
        logic [OPERAND_BITS-1:0] divisor;
        logic [REM_BITS-1:0]     rem;
        logic [QUOT_BITS-1:0]    dvd;
        logic [QUOT_BITS-1:0]    quo;
        logic [WHOLE_BITS-1:0]   res;
        t_status                 status;
    } t_stage;

endpackage
`default_nettype wire

FILE: sv/asmd_div_step.sv
// asmd_div_step: one restoring division step on a pipeline stage word
// depends on asmd_pkg
`timescale 1ns / 1ps
`default_nettype none
module asmd_div_step (
    input  asmd_pkg::t_stage i_stg,
    output asmd_pkg::t_stage o_stg
);

    logic [asmd_pkg::REM_BITS-1:0] rem_sh;
    logic [asmd_pkg::REM_BITS:0]   diff;
    logic                          qbit;

    always_comb begin
        rem_sh = {i_stg.rem[asmd_pkg::REM_BITS-2:0], i_stg.dvd[asmd_pkg::QUOT_BITS-1]};
        diff   = {1'b0, rem_sh} - {2'b00, i_stg.divisor};
        qbit   = ~diff[asmd_pkg::REM_BITS];
        o_stg      = i_stg;
        o_stg.rem  = qbit ? diff[asmd_pkg::REM_BITS-1:0] : rem_sh;
        o_stg.dvd  = {i_stg.dvd[asmd_pkg::QUOT_BITS-2:0], 1'b0};
        o_stg.quo  = {i_stg.quo[asmd_pkg::QUOT_BITS-2:0], qbit};
    end

endmodule
`default_nettype wire

FILE: sv/add_sub_mul_div_unit.sv
// add_sub_mul_div_unit: pipelined unsigned add, subtract, multiply, divide
// depends on asmd_pkg and asmd_div_step
// pipeline: input register, one divider stage per quotient bit, output register
// throughput: one word per cycle; a stall on a valid output holds all stages
// reset: synchronous active-low reset clears all valid bits
`timescale 1ns / 1ps
`default_nettype none
module add_sub_mul_div_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire  [1:0]                           i_func,
    input  wire  [asmd_pkg::OPERAND_BITS-1:0]    i_operand_a,
    input  wire  [asmd_pkg::OPERAND_BITS-1:0]    i_operand_b,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic [asmd_pkg::WHOLE_BITS-1:0]      o_whole_part,
    output logic [asmd_pkg::FRACTION_BITS-1:0]   o_fraction_bits,
    output logic [asmd_pkg::STATUS_BITS-1:0]     o_status
);

    localparam int NQ = asmd_pkg::QUOT_BITS;

    asmd_pkg::t_stage r_stg [0:NQ];
    asmd_pkg::t_stage n_stg [0:NQ];
    asmd_pkg::t_stage n_in;

    logic                                r_valid;
    logic [asmd_pkg::WHOLE_BITS-1:0]     r_whole;
    logic [asmd_pkg::FRACTION_BITS-1:0]  r_frac;
    asmd_pkg::t_status                   r_status;
    logic                                adv;

    assign adv     = ~r_valid | ~i_stall;
    assign o_stall = ~adv;

    always_comb begin
        n_in         = '0;
        n_in.valid   = i_valid;
        n_in.func    = asmd_pkg::t_func'(i_func);
        n_in.divisor = i_operand_b;
        n_in.dvd     = {i_operand_a, {asmd_pkg::FRACTION_BITS{1'b0}}};
        n_in.status  = asmd_pkg::ST_OK;
        case (asmd_pkg::t_func'(i_func))
            asmd_pkg::FUNC_ADD: begin
                n_in.res = asmd_pkg::WHOLE_BITS'({1'b0, i_operand_a} + {1'b0, i_operand_b});
            end
            asmd_pkg::FUNC_SUB: begin
                if (i_operand_a >= i_operand_b) begin
                    n_in.res = asmd_pkg::WHOLE_BITS'(i_operand_a - i_operand_b);
                end else begin
                    n_in.status = asmd_pkg::ST_NEG;
                end
            end
            asmd_pkg::FUNC_MUL: begin
                n_in.res = asmd_pkg::WHOLE_BITS'(i_operand_a) *
                           asmd_pkg::WHOLE_BITS'(i_operand_b);
            end
            default: begin
                if (i_operand_b == '0) begin
                    n_in.status = asmd_pkg::ST_DIV0;
                end
            end
        endcase
    end

    assign n_stg[0] = n_in;

    for (genvar k = 1; k <= NQ; k++) begin : g_div
        asmd_div_step u_step (
            .i_stg (r_stg[k-1]),
            .o_stg (n_stg[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NQ; k++) begin
                r_stg[k].valid <= 1'b0;
            end
            r_valid <= 1'b0;
        end else if (adv) begin
            for (int k = 0; k <= NQ; k++) begin
                r_stg[k] <= n_stg[k];
            end
            if (r_stg[NQ].func == asmd_pkg::FUNC_DIV &&
                r_stg[NQ].status == asmd_pkg::ST_OK) begin
                r_whole <= asmd_pkg::WHOLE_BITS'(r_stg[NQ].quo[NQ-1:asmd_pkg::FRACTION_BITS]);
                r_frac  <= r_stg[NQ].quo[asmd_pkg::FRACTION_BITS-1:0];
            end else begin
                r_whole <= r_stg[NQ].res;
                r_frac  <= '0;
            end
            r_status <= r_stg[NQ].status;
            r_valid  <= r_stg[NQ].valid;
        end
    end

    assign o_valid         = r_valid;
    assign o_whole_part    = r_whole;
    assign o_fraction_bits = r_frac;
    assign o_status        = r_status;

endmodule
`default_nettype wire

FILE: tb/tb_add_sub_mul_div_unit.sv
// tb_add_sub_mul_div_unit: random and directed test of the add/sub/mul/div unit
// depends on asmd_pkg and add_sub_mul_div_unit; checks every result word against
// a predictor built in, with random input gaps and random output stalls
`timescale 1ns / 1ps
module tb_add_sub_mul_div_unit;

    localparam int OPW = asmd_pkg::OPERAND_BITS;
    localparam int FRW = asmd_pkg::FRACTION_BITS;
    localparam int WHW = asmd_pkg::WHOLE_BITS;

    typedef struct {
        asmd_pkg::t_func func;
        logic [OPW-1:0]  a;
        logic [OPW-1:0]  b;
    } t_op;

    typedef struct {
        logic [WHW-1:0]    whole;
        logic [FRW-1:0]    frac;
        asmd_pkg::t_status status;
    } t_answer;

    localparam int IDLE_LIMIT = 5000;
    localparam logic [OPW-1:0] OP_MAX = {OPW{1'b1}};

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [1:0]                         in_func = '0;
    logic [OPW-1:0]                     in_a = '0;
    logic [OPW-1:0]                     in_b = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [WHW-1:0]                     out_whole;
    logic [FRW-1:0]                     out_frac;
    logic [asmd_pkg::STATUS_BITS-1:0]   out_status;

    t_op     pending_ops[$];
    t_answer expected_answers[$];
    int      errors = 0;
    int      words_in = 0;
    int      words_out = 0;
    int      in_gap = 0;
    int      out_gap = 0;
    int      idle_cycles = 0;
    int      holdoff = 0;
    bit      holdoff_done = 1'b0;
    bit      feeding_done = 1'b0;
    int      op_count[4];

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    add_sub_mul_div_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_func(in_func), .i_operand_a(in_a), .i_operand_b(in_b),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_whole_part(out_whole), .o_fraction_bits(out_frac), .o_status(out_status)
    );

    function automatic t_answer compute_answer(t_op op);
        t_answer r;
        logic [OPW+FRW-1:0] q;
        r.whole = '0;
        r.frac = '0;
        r.status = asmd_pkg::ST_OK;
        case (op.func)
            asmd_pkg::FUNC_ADD: r.whole = WHW'(op.a) + WHW'(op.b);
            asmd_pkg::FUNC_SUB: begin
                if (op.a >= op.b) r.whole = WHW'(op.a - op.b);
                else r.status = asmd_pkg::ST_NEG;
            end
            asmd_pkg::FUNC_MUL: r.whole = WHW'(op.a) * WHW'(op.b);
            default: begin
                if (op.b == '0) begin
                    r.status = asmd_pkg::ST_DIV0;
                end else begin
                    q = {op.a, {FRW{1'b0}}} / (OPW+FRW)'(op.b);
                    r.whole = WHW'(q >> FRW);
                    r.frac = q[FRW-1:0];
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [OPW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return OP_MAX;
            2: return OPW'($urandom_range(0, 15));
            3: return OP_MAX - OPW'($urandom_range(0, 15));
            4: return OPW'(1) << $urandom_range(0, OPW - 1);
            5: return OPW'($urandom_range(0, 65535));
            default: return OPW'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_op(asmd_pkg::t_func f, logic [OPW-1:0] a, logic [OPW-1:0] b);
        t_op op;
        op.func = f;
        op.a = a;
        op.b = b;
        pending_ops.push_back(op);
    endtask

    initial begin
        t_op op;
        add_op(asmd_pkg::FUNC_ADD, '0, '0);
        add_op(asmd_pkg::FUNC_ADD, OP_MAX, OP_MAX);
        add_op(asmd_pkg::FUNC_ADD, OP_MAX, OPW'(1));
        add_op(asmd_pkg::FUNC_SUB, OP_MAX, OP_MAX);
        add_op(asmd_pkg::FUNC_SUB, OP_MAX, '0);
        add_op(asmd_pkg::FUNC_SUB, '0, OPW'(1));
        add_op(asmd_pkg::FUNC_SUB, OPW'(5), OP_MAX);
        add_op(asmd_pkg::FUNC_MUL, OP_MAX, OP_MAX);
        add_op(asmd_pkg::FUNC_MUL, OP_MAX, '0);
        add_op(asmd_pkg::FUNC_MUL, OPW'(1), OP_MAX);
        add_op(asmd_pkg::FUNC_DIV, OP_MAX, '0);
        add_op(asmd_pkg::FUNC_DIV, '0, '0);
        add_op(asmd_pkg::FUNC_DIV, OP_MAX, OPW'(1));
        add_op(asmd_pkg::FUNC_DIV, OPW'(1), OP_MAX);
        add_op(asmd_pkg::FUNC_DIV, OPW'(7), OPW'(3));
        add_op(asmd_pkg::FUNC_DIV, '0, OPW'(9));
        add_op(asmd_pkg::FUNC_DIV, OP_MAX, OP_MAX);
        add_op(asmd_pkg::FUNC_DIV, OP_MAX - OPW'(1), OP_MAX);
        add_op(asmd_pkg::FUNC_DIV, OPW'(1), OPW'(16));
        add_op(asmd_pkg::FUNC_DIV, OPW'(1), OPW'(17));
        for (int i = 0; i < 1450; i++) begin
            op.func = asmd_pkg::t_func'($urandom_range(0, 3));
            op.a = pick_operand();
            op.b = pick_operand();
            if (op.func == asmd_pkg::FUNC_DIV && $urandom_range(0, 3) == 0)
                op.b = OPW'($urandom_range(1, 255));
            pending_ops.push_back(op);
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (feeding_done && expected_answers.size() == 0);
        repeat (50) @(posedge clk);
        $display("covered %0d words in, %0d out: add %0d sub %0d mul %0d div %0d",
                 words_in, words_out, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("including operand extremes, clamped differences and divide by zero");
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // driver
    always @(posedge clk) begin
        t_op op;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                op.func = asmd_pkg::t_func'(in_func);
                op.a = in_a;
                op.b = in_b;
                expected_answers.push_back(compute_answer(op));
                op_count[in_func]++;
                words_in++;
            end
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    op = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    in_func <= op.func;
                    in_a <= op.a;
                    in_b <= op.b;
                    in_gap = (words_in > 600 && words_in < 800) ? 0 : pick_gap();
                end else begin
                    in_valid <= 1'b0;
                    feeding_done = 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_answer want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                words_out++;
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected word whole=%h frac=%h status=%0d",
                             $time, out_whole, out_frac, out_status);
                    errors++;
                end else begin
                    want = expected_answers.pop_front();
                    if (out_whole !== want.whole) begin
                        $display("%0t: whole expected %h actual %h", $time, want.whole, out_whole);
                        errors++;
                    end
                    if (out_frac !== want.frac) begin
                        $display("%0t: fraction expected %h actual %h", $time, want.frac, out_frac);
                        errors++;
                    end
                    if (out_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, out_status);
                        errors++;
                    end
                end
            end
            // long hold-off once so the pipeline fills and backs up
            if (!holdoff_done && words_in >= 650) begin
                holdoff_done = 1'b1;
                holdoff = 200;
            end
            if (holdoff > 0) begin
                holdoff--;
                out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                out_stall <= 1'b1;
            end else begin
                out_gap = (words_out % 300 < 100) ? 0 : pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d words outstanding", $time, expected_answers.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
